@@ design/ccsr_pkg.sv @@
// Shared types and constants for the clipped circle span rasterizer.
// No dependencies; every other design file references this package.
package ccsr_pkg;

  localparam int COORD_W    = 12;  // signed center coordinates
  localparam int WIDE_W     = 13;  // coordinate arithmetic with headroom
  localparam int RAD_W      = 8;
  localparam int DIM_W      = 7;   // area size registers
  localparam int POS_W      = 6;   // screen rows / columns
  localparam int SQ_W       = 16;  // r*r and remainders
  localparam int DY_W       = 9;   // row offset from center, |dy| <= 255
  localparam int ROOT_STAGES = 8;  // one result bit per stage
  localparam int JOB_DEPTH  = 2;
  localparam int JOB_PTR_W  = 1;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] AREA_WIDTH_RST  = 7'd32;
  localparam logic [DIM_W-1:0] AREA_HEIGHT_RST = 7'd64;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic        [RAD_W-1:0]   radius;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] span_row;
    logic [POS_W-1:0] span_start;
    logic [POS_W-1:0] span_end;
    logic             span_empty;
    logic             last_span;
  } out_item_t;

  // One circle after classification: the rows to walk and what each row needs.
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic        [DIM_W-1:0]   area_w;
    logic        [SQ_W-1:0]    rr;
    logic        [POS_W-1:0]   y_first;
    logic        [POS_W-1:0]   y_last;
    logic signed [DY_W-1:0]    dy_first;
  } job_t;

  // One row in flight through the square root pipeline.
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic        [DIM_W-1:0]   area_w;
    logic        [SQ_W-1:0]    rem;
    logic        [RAD_W-1:0]   root;
    logic        [POS_W-1:0]   row;
    logic                      last;
  } row_t;

endpackage

@@ design/clipped_circle_span_rasterizer_core.sv @@
// Clipped circle span rasterizer, top level. Depends on ccsr_pkg, ccsr_front,
// ccsr_back. A circle's first span passes through the queue, row setup, eight
// square root stages and one clip stage before it leaves.
// Throughput: one span per cycle while the output is not stalled, with a gap
// between circles while the row sequencer loads the next job.
// Dropped circles are never queued. Reset: area 32x64, queue and pipeline empty.
module clipped_circle_span_rasterizer_core #(
  parameter int MAX_AREA_DIM = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // circle requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ccsr_pkg::in_item_t                  in_data,
  // span results
  output logic                                out_valid,
  input  logic                                out_stall,
  output ccsr_pkg::out_item_t                 out_data,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ccsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccsr_pkg::DIM_W-1:0]          cfg_data
);

  localparam logic [ccsr_pkg::DIM_W-1:0] DIM_MAX = ccsr_pkg::DIM_W'(MAX_AREA_DIM);

  logic [ccsr_pkg::DIM_W-1:0] area_w_r, area_h_r;
  logic [ccsr_pkg::DIM_W-1:0] eff_w, eff_h;
  logic                       job_pop, job_avail;
  ccsr_pkg::job_t             job_head;

  // Register port never backs up; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_w_r <= ccsr_pkg::AREA_WIDTH_RST;
      area_h_r <= ccsr_pkg::AREA_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ccsr_pkg::REG_AREA_WIDTH:  area_w_r <= cfg_data;
        ccsr_pkg::REG_AREA_HEIGHT: area_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A size of zero behaves as one; oversize saturates at the area limit.
  always_comb begin
    eff_w = (area_w_r == '0) ? ccsr_pkg::DIM_W'(1)
          : (area_w_r > DIM_MAX) ? DIM_MAX : area_w_r;
    eff_h = (area_h_r == '0) ? ccsr_pkg::DIM_W'(1)
          : (area_h_r > DIM_MAX) ? DIM_MAX : area_h_r;
  end

  // Front: classify and clip row range; queue lets it run ahead of the back.
  ccsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .job_pop   (job_pop),
    .job_avail (job_avail),
    .job_head  (job_head)
  );

  // Back: one row per cycle, unless the output stalls, through the square root pipeline.
  ccsr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (job_avail),
    .job_head  (job_head),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ design/ccsr_job_fifo.sv @@
// Two-entry job queue between the circle classifier and the span engine.
// Depends on ccsr_pkg (job_t, depth constants).
module ccsr_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ccsr_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ccsr_pkg::job_t head
);

  ccsr_pkg::job_t                    mem_r [ccsr_pkg::JOB_DEPTH];
  logic [ccsr_pkg::JOB_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ccsr_pkg::JOB_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ccsr_pkg::JOB_PTR_W:0]      count_r, count_nxt;
  logic                              do_push, do_pop;

  assign full      = (count_r == (ccsr_pkg::JOB_PTR_W+1)'(ccsr_pkg::JOB_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (ccsr_pkg::JOB_PTR_W)'(do_push);
    rd_ptr_nxt = rd_ptr_r + (ccsr_pkg::JOB_PTR_W)'(do_pop);
    count_nxt  = count_r + (ccsr_pkg::JOB_PTR_W+1)'(do_push)
                         - (ccsr_pkg::JOB_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/ccsr_front.sv @@
// Circle classifier: drops empty/off-screen circles, clips the row range
// and queues one job per visible circle. Depends on ccsr_pkg, ccsr_job_fifo.
module ccsr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ccsr_pkg::in_item_t         in_data,
  input  logic [ccsr_pkg::DIM_W-1:0] eff_w,
  input  logic [ccsr_pkg::DIM_W-1:0] eff_h,
  input  logic                       job_pop,
  output logic                       job_avail,
  output ccsr_pkg::job_t             job_head
);

  logic signed [ccsr_pkg::WIDE_W-1:0] cx_e, cy_e, r_e, w_e, h_e;
  logic signed [ccsr_pkg::WIDE_W-1:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [ccsr_pkg::WIDE_W-1:0] y_first, y_last, dy_first;
  logic                               drop, fifo_full;
  ccsr_pkg::job_t                     job;

  always_comb begin
    cx_e = ccsr_pkg::WIDE_W'(in_data.center_x);
    cy_e = ccsr_pkg::WIDE_W'(in_data.center_y);
    r_e  = signed'({5'd0, in_data.radius});
    w_e  = signed'({6'd0, eff_w});
    h_e  = signed'({6'd0, eff_h});
    x_lo = cx_e - r_e;
    x_hi = cx_e + r_e;
    y_lo = cy_e - r_e;
    y_hi = cy_e + r_e;
    drop = (in_data.radius == '0) || (x_hi < 0) || (x_lo >= w_e)
        || (y_hi < 0) || (y_lo >= h_e);
    y_first  = (y_lo < 0) ? '0 : y_lo;
    y_last   = (y_hi > h_e - 1) ? h_e - 1 : y_hi;
    dy_first = y_first - cy_e;

    job.cx       = in_data.center_x;
    job.area_w   = eff_w;
    job.rr       = {8'd0, in_data.radius} * {8'd0, in_data.radius};
    job.y_first  = y_first[ccsr_pkg::POS_W-1:0];
    job.y_last   = y_last[ccsr_pkg::POS_W-1:0];
    job.dy_first = dy_first[ccsr_pkg::DY_W-1:0];
  end

  assign in_stall = fifo_full;

  ccsr_job_fifo u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !drop),
    .push_data (job),
    .full      (fifo_full),
    .pop       (job_pop),
    .not_empty (job_avail),
    .head      (job_head)
  );

endmodule

@@ design/ccsr_back.sv @@
// Span engine: walks the rows of one job, runs each through a bit-per-stage
// square root pipeline, clips the span and holds it in the output register.
// Depends on ccsr_pkg.
module ccsr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_avail,
  input  ccsr_pkg::job_t      job_head,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ccsr_pkg::out_item_t out_data
);

  localparam int NS = ccsr_pkg::ROOT_STAGES;

  // row sequencer
  logic                               active_r;
  ccsr_pkg::job_t                     job_r;
  logic [ccsr_pkg::POS_W-1:0]         cur_y_r;
  logic signed [ccsr_pkg::DY_W-1:0]   cur_dy_r;
  logic                               adv, row_last;
  logic [ccsr_pkg::DY_W-1:0]          dy_neg;
  logic [ccsr_pkg::RAD_W-1:0]         abs_dy;
  logic [ccsr_pkg::SQ_W-1:0]          dy_sq;
  ccsr_pkg::row_t                     issue;

  // pipeline and output
  ccsr_pkg::row_t                     sq_r   [NS+1];
  logic                               sq_v_r [NS+1];
  logic                               out_valid_r;
  ccsr_pkg::out_item_t                out_data_r, out_nxt;
  logic signed [ccsr_pkg::WIDE_W-1:0] cx_e, dx_e, w_e, xs, xe;
  logic                               empty;

  // whole pipeline moves together when the output slot frees up
  assign adv      = !out_valid_r || !out_stall;
  assign job_pop  = !active_r && job_avail;
  assign row_last = (cur_y_r == job_r.y_last);

  always_comb begin
    dy_neg       = ccsr_pkg::DY_W'(-cur_dy_r);
    abs_dy       = cur_dy_r[ccsr_pkg::DY_W-1] ? dy_neg[ccsr_pkg::RAD_W-1:0]
                                              : cur_dy_r[ccsr_pkg::RAD_W-1:0];
    dy_sq        = {8'd0, abs_dy} * {8'd0, abs_dy};
    issue.cx     = job_r.cx;
    issue.area_w = job_r.area_w;
    issue.rem    = job_r.rr - dy_sq;  // never negative: |dy| <= r
    issue.root   = '0;
    issue.row    = cur_y_r;
    issue.last   = row_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (job_pop) begin
      active_r <= 1'b1;
    end else if (active_r && adv && row_last) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r    <= job_head;
      cur_y_r  <= job_head.y_first;
      cur_dy_r <= job_head.dy_first;
    end else if (active_r && adv) begin
      cur_y_r  <= cur_y_r + 1'b1;
      cur_dy_r <= cur_dy_r + signed'(ccsr_pkg::DY_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0] <= issue;
    end
  end

  // stage k decides root bit 7-k
  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam logic [ccsr_pkg::RAD_W-1:0] BIT = ccsr_pkg::RAD_W'(1 << (NS - 1 - k));
    logic [ccsr_pkg::RAD_W-1:0] trial;
    logic [ccsr_pkg::SQ_W-1:0]  trial_sq;
    ccsr_pkg::row_t             nxt;

    always_comb begin
      trial    = sq_r[k].root | BIT;
      trial_sq = {8'd0, trial} * {8'd0, trial};
      nxt      = sq_r[k];
      if (trial_sq <= sq_r[k].rem) begin
        nxt.root = trial;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1] <= nxt;
      end
    end
  end

  // clip to the area and flag empty rows
  always_comb begin
    cx_e = ccsr_pkg::WIDE_W'(sq_r[NS].cx);
    dx_e = signed'({5'd0, sq_r[NS].root});
    w_e  = signed'({6'd0, sq_r[NS].area_w});
    xs   = cx_e - dx_e;
    xe   = cx_e + dx_e;
    if (xs < 0) begin
      xs = '0;
    end
    if (xe > w_e - 1) begin
      xe = w_e - 1;
    end
    empty = (xs > xe);
    out_nxt.span_row   = sq_r[NS].row;
    out_nxt.span_start = empty ? '0 : xs[ccsr_pkg::POS_W-1:0];
    out_nxt.span_end   = empty ? '0 : xe[ccsr_pkg::POS_W-1:0];
    out_nxt.span_empty = empty;
    out_nxt.last_span  = sq_r[NS].last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sq_v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
